// ----- rtl/oetp_pkg.sv -----
// shared constants and controller/datapath interface types for the odd-even partition block
package oetp_pkg;

	localparam int WORD_W      = 32;
	localparam int DEPTH_DEF   = 64;
	localparam logic [WORD_W-1:0] ODD_BIT = 32'h0000_0001;

	typedef struct packed {
		logic accept;
		logic start;
		logic rd_pair;
		logic step_f;
		logic step_b;
		logic swap_lo;
		logic swap_hi;
		logic emit_rd;
		logic emit_ld;
		logic done;
	} cmd_t;

	typedef struct packed {
		logic f_lt_b;
		logic f_odd;
		logic b_odd;
		logic k_last;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/oetp_ctrl.sv -----
// controller state machine: load, partition walk and emission sequencing
module oetp_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           block_end,
	output logic           in_stall,
	input  oetp_pkg::sts_t sts,
	output oetp_pkg::cmd_t cmd
);
	import oetp_pkg::*;

	localparam logic [2:0] ST_LOAD = 3'd0;
	localparam logic [2:0] ST_PRD  = 3'd1;
	localparam logic [2:0] ST_PEV  = 3'd2;
	localparam logic [2:0] ST_PW2  = 3'd3;
	localparam logic [2:0] ST_ERD  = 3'd4;
	localparam logic [2:0] ST_ELD  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_LOAD);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (block_end) begin
						cmd.start = 1'b1;
						state_d   = ST_PRD;
					end
				end
			end
			ST_PRD: begin
				if (sts.f_lt_b) begin
					cmd.rd_pair = 1'b1;
					state_d     = ST_PEV;
				end else begin
					state_d = ST_ERD;
				end
			end
			ST_PEV: begin
				if (sts.f_odd) begin
					cmd.step_f = 1'b1;
					state_d    = ST_PRD;
				end else if (!sts.b_odd) begin
					cmd.step_b = 1'b1;
					state_d    = ST_PRD;
				end else begin
					cmd.swap_lo = 1'b1;
					state_d     = ST_PW2;
				end
			end
			ST_PW2: begin
				cmd.swap_hi = 1'b1;
				state_d     = ST_PRD;
			end
			ST_ERD: begin
				cmd.emit_rd = 1'b1;
				state_d     = ST_ELD;
			end
			ST_ELD: begin
				if (sts.out_free) begin
					cmd.emit_ld = 1'b1;
					if (sts.k_last) begin
						cmd.done = 1'b1;
						state_d  = ST_LOAD;
					end else begin
						state_d = ST_ERD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/oetp_dp.sv -----
// datapath: element store, partition pointers, emission counter and output register
module oetp_dp #(
	parameter int BLOCK_DEPTH = oetp_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  oetp_pkg::cmd_t                     cmd,
	output oetp_pkg::sts_t                     sts,
	input  logic signed [oetp_pkg::WORD_W-1:0] word_value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [oetp_pkg::WORD_W-1:0] out_value,
	output logic                               out_last,
	output logic                               overflowed
);
	import oetp_pkg::*;

	localparam int IDX_W = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
	localparam int CNT_W = $clog2(BLOCK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BLOCK_DEPTH);

	logic [WORD_W-1:0] store_q [BLOCK_DEPTH];
	logic [WORD_W-1:0] rd_a_q;
	logic [WORD_W-1:0] rd_b_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  k_q;
	logic [IDX_W-1:0]  f_q;
	logic [IDX_W-1:0]  b_q;
	logic              drop_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_value_q;
	logic              out_last_q;
	logic              overflowed_q;

	logic              has_room;
	logic [CNT_W-1:0]  count_new;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	logic [WORD_W-1:0] wr_data;
	logic [IDX_W-1:0]  rd_a_addr;
	logic              b_dec_ok;

	assign has_room  = (fill_q < DEPTH_C);
	assign count_new = has_room ? CNT_W'(fill_q + CNT_W'(1)) : fill_q;
	assign b_dec_ok  = (({1'b0, f_q} + (IDX_W+1)'(1)) < {1'b0, b_q});

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = b_q;
		wr_data = rd_a_q;
		if (cmd.accept && has_room) begin
			wr_en   = 1'b1;
			wr_addr = fill_q[IDX_W-1:0];
			wr_data = word_value;
		end else if (cmd.swap_lo) begin
			wr_en   = 1'b1;
			wr_addr = f_q;
			wr_data = rd_b_q;
		end else if (cmd.swap_hi) begin
			wr_en = 1'b1;
		end
	end

	assign rd_a_addr = cmd.emit_rd ? k_q[IDX_W-1:0] : f_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		if (cmd.rd_pair || cmd.emit_rd) begin
			rd_a_q <= store_q[rd_a_addr];
		end
		if (cmd.rd_pair) begin
			rd_b_q <= store_q[b_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			drop_q <= 1'b0;
			f_q    <= '0;
			b_q    <= '0;
			k_q    <= '0;
		end else begin
			if (cmd.accept) begin
				fill_q <= count_new;
				if (!has_room) begin
					drop_q <= 1'b1;
				end
			end
			if (cmd.start) begin
				f_q <= '0;
				b_q <= IDX_W'(count_new - CNT_W'(1));
				k_q <= '0;
			end
			if (cmd.step_f) begin
				f_q <= IDX_W'(f_q + IDX_W'(1));
			end
			if (cmd.step_b) begin
				b_q <= IDX_W'(b_q - IDX_W'(1));
			end
			if (cmd.swap_hi) begin
				f_q <= IDX_W'(f_q + IDX_W'(1));
				if (b_dec_ok) begin
					b_q <= IDX_W'(b_q - IDX_W'(1));
				end
			end
			if (cmd.emit_ld) begin
				k_q <= CNT_W'(k_q + CNT_W'(1));
			end
			if (cmd.done) begin
				fill_q <= '0;
				drop_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			out_value_q  <= rd_a_q;
			out_last_q   <= (CNT_W'(k_q + CNT_W'(1)) == fill_q);
			overflowed_q <= drop_q;
		end
	end

	assign sts.f_lt_b   = (f_q < b_q);
	assign sts.f_odd    = ((rd_a_q & ODD_BIT) != '0);
	assign sts.b_odd    = ((rd_b_q & ODD_BIT) != '0);
	assign sts.k_last   = (CNT_W'(k_q + CNT_W'(1)) == fill_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_last   = out_last_q;
	assign overflowed = overflowed_q;

endmodule

// ----- rtl/odd_even_two_pointer_partition.sv -----
// top level of the odd-before-even two-pointer partition block
//
// input channel (in_valid, in_stall, word_value, block_end): one signed word per
// transfer; in_stall is low only while the block is loading. a transfer with
// block_end set closes the block. words past BLOCK_DEPTH are dropped.
// after the closing transfer the stored block of n words is reordered in place:
// each pointer step is a registered dual read of the store plus a decision
// state; a swap writes the front word in the decision state and the back word
// in the next cycle, then moves the front pointer up and moves the back pointer
// down only if it lay more than one place above the front pointer.
// then the n words leave on the output channel (out_valid, out_stall, out_value,
// out_last, overflowed), each as one store read and one output load.
// out_last marks the final word, overflowed marks every word of a block that
// lost words. loading of the next block starts as soon as the last word sits
// in the output register.
// a stalled receiver holds the output register and pauses emission.
// reset empties the block, clears the drop flag and the output valid flag.
module odd_even_two_pointer_partition #(
	parameter int BLOCK_DEPTH = oetp_pkg::DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [oetp_pkg::WORD_W-1:0] word_value,
	input  logic                               block_end,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [oetp_pkg::WORD_W-1:0] out_value,
	output logic                               out_last,
	output logic                               overflowed
);
	import oetp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	oetp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.block_end (block_end),
		.in_stall  (in_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	oetp_dp #(
		.BLOCK_DEPTH (BLOCK_DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.word_value (word_value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_value  (out_value),
		.out_last   (out_last),
		.overflowed (overflowed)
	);

endmodule

// ----- verif/odd_even_two_pointer_partition_test.sv -----
// self-checking testbench for the odd-before-even two-pointer partition block
module odd_even_two_pointer_partition_test;

	import oetp_pkg::*;

	localparam int BLOCK_DEPTH  = DEPTH_DEF;
	localparam int ITEM_TARGET  = 370;
	localparam int TAIL_ITEMS   = 40;
	localparam int LONG_HOLD    = 300;
	localparam int HOLD_AFTER   = 150;
	localparam int STUCK_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 50;

	typedef enum int {
		PAR_ANY,
		PAR_ODD,
		PAR_EVEN
	} parity_mode_t;

	typedef struct {
		logic [WORD_W-1:0] value;
		logic              last;
		int                gap_after;
		bit                drain_first;
	} word_item_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     last;
		logic                     ovf;
	} partition_result_t;

	logic                     clk        = 1'b0;
	logic                     arst_n     = 1'b0;
	logic                     in_valid   = 1'b0;
	logic                     in_stall;
	logic signed [WORD_W-1:0] word_value = '0;
	logic                     block_end  = 1'b0;
	logic                     out_valid;
	logic                     out_stall  = 1'b0;
	logic signed [WORD_W-1:0] out_value;
	logic                     out_last;
	logic                     overflowed;

	word_item_t        pending_words[$];
	word_item_t        next_item;
	logic [WORD_W-1:0] open_block[$];
	logic              block_dropped = 1'b0;
	partition_result_t expected_order[$];

	int error_count    = 0;
	int results_seen   = 0;
	int stuck_cycles   = 0;
	int send_gap       = 0;
	int sender_quiet   = 0;
	int hold_left      = 0;
	int quiet_left     = 0;
	bit long_hold_done = 1'b0;

	odd_even_two_pointer_partition #(
		.BLOCK_DEPTH(BLOCK_DEPTH)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.word_value(word_value),
		.block_end (block_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_value (out_value),
		.out_last  (out_last),
		.overflowed(overflowed)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// in-place two-pointer pass over the closed block, then queue its words in order
	function automatic void partition_open_block();
		int                front;
		int                back;
		int                k;
		logic [WORD_W-1:0] t;
		partition_result_t r;
		front = 0;
		back = open_block.size() - 1;
		while (front < back) begin
			while (front < back && (open_block[front] & ODD_BIT) != '0)
				front++;
			while (front < back && (open_block[back] & ODD_BIT) == '0)
				back--;
			if (front < back) begin
				t = open_block[front];
				open_block[front] = open_block[back];
				open_block[back] = t;
			end
		end
		for (k = 0; k < open_block.size(); k++) begin
			r.value = open_block[k];
			r.last = (k + 1 == open_block.size());
			r.ovf = block_dropped;
			expected_order.push_back(r);
		end
		open_block.delete();
		block_dropped = 1'b0;
	endfunction

	function automatic void store_word(logic [WORD_W-1:0] w, logic is_end);
		if (open_block.size() < BLOCK_DEPTH)
			open_block.push_back(w);
		else
			block_dropped = 1'b1;
		if (is_end)
			partition_open_block();
	endfunction

	function automatic void check_result();
		partition_result_t want;
		if (expected_order.size() == 0) begin
			error_count++;
			$display("%0t: unexpected result, expected none, actual %h last %b overflowed %b",
				$time, out_value, out_last, overflowed);
		end else begin
			want = expected_order.pop_front();
			if (out_value !== want.value) begin
				error_count++;
				$display("%0t: out_value expected %h actual %h", $time, want.value, out_value);
			end
			if (out_last !== want.last) begin
				error_count++;
				$display("%0t: out_last expected %b actual %b", $time, want.last, out_last);
			end
			if (overflowed !== want.ovf) begin
				error_count++;
				$display("%0t: overflowed expected %b actual %b", $time, want.ovf, overflowed);
			end
		end
	endfunction

	function automatic logic [WORD_W-1:0] rand_word(parity_mode_t mode);
		logic [WORD_W-1:0] w;
		case ($urandom_range(0, 9))
			0: w = 32'h8000_0000;
			1: w = 32'h7fff_ffff;
			2: w = 32'hffff_ffff;
			3: w = 32'h0000_0000;
			default: w = $urandom;
		endcase
		if (mode == PAR_ODD)
			w[0] = 1'b1;
		else if (mode == PAR_EVEN)
			w[0] = 1'b0;
		return w;
	endfunction

	function automatic void add_word(logic [WORD_W-1:0] w, logic is_end, bit drain);
		word_item_t it;
		it.value = w;
		it.last = is_end;
		it.drain_first = drain;
		if (sender_quiet > 0) begin
			sender_quiet--;
			it.gap_after = 0;
		end else if ($urandom_range(0, 39) == 0) begin
			sender_quiet = $urandom_range(20, 80);
			it.gap_after = 0;
		end else begin
			it.gap_after = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : 0;
		end
		pending_words.push_back(it);
	endfunction

	function automatic void add_block(int n, parity_mode_t mode, bit drain);
		int i;
		for (i = 0; i < n; i++)
			add_word(rand_word(mode), i == n - 1, drain && i == 0);
	endfunction

	function automatic void add_random_block(bit drain);
		parity_mode_t mode;
		case ($urandom_range(0, 5))
			0: mode = PAR_ODD;
			1: mode = PAR_EVEN;
			default: mode = PAR_ANY;
		endcase
		add_block($urandom_range(1, 12), mode, drain);
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				store_word(word_value, block_end);
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_words.size() == 0 ||
						(pending_words[0].drain_first && expected_order.size() != 0)) begin
					in_valid <= 1'b0;
				end else begin
					next_item = pending_words.pop_front();
					in_valid <= 1'b1;
					word_value <= next_item.value;
					block_end <= next_item.last;
					send_gap = next_item.gap_after;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_result();
				results_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
				long_hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				out_stall <= 1'b1;
			end else if (quiet_left > 0 || pending_words.size() < TAIL_ITEMS) begin
				if (quiet_left > 0)
					quiet_left--;
				out_stall <= 1'b0;
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						hold_left = $urandom_range(0, 9);
						out_stall <= 1'b1;
					end
					3: begin
						quiet_left = $urandom_range(30, 120);
						out_stall <= 1'b0;
					end
					default: out_stall <= 1'b0;
				endcase
			end
		end
	end

	// watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	initial begin
		int i;
		// single words at the extremes
		add_word(32'h7fff_ffff, 1'b1, 1'b0);
		add_word(32'h8000_0000, 1'b1, 1'b0);
		// even then odd swaps, odd then even stays
		add_word(32'h0000_0000, 1'b0, 1'b0);
		add_word(32'hffff_ffff, 1'b1, 1'b0);
		add_word(32'h0000_0001, 1'b0, 1'b0);
		add_word(32'hffff_fffe, 1'b1, 1'b0);
		// all odd
		add_word(32'hffff_ffff, 1'b0, 1'b0);
		add_word(32'h0000_0003, 1'b0, 1'b0);
		add_word(32'h7fff_ffff, 1'b0, 1'b0);
		add_word(32'hffff_fffd, 1'b1, 1'b0);
		// all even
		add_word(32'h0000_0000, 1'b0, 1'b0);
		add_word(32'hffff_fffe, 1'b0, 1'b0);
		add_word(32'h8000_0000, 1'b0, 1'b0);
		add_word(32'h0000_0002, 1'b1, 1'b0);
		// mixed with negative odd words
		add_word(32'h0000_0000, 1'b0, 1'b0);
		add_word(32'h0000_0002, 1'b0, 1'b0);
		add_word(32'hffff_fffb, 1'b0, 1'b0);
		add_word(32'h0000_0007, 1'b0, 1'b0);
		add_word(32'h0000_0004, 1'b0, 1'b0);
		add_word(32'hffff_ffff, 1'b1, 1'b0);
		add_word(32'hffff_fffe, 1'b0, 1'b0);
		add_word(32'h7fff_fffe, 1'b0, 1'b0);
		add_word(32'hffff_ffff, 1'b1, 1'b0);

		add_random_block(1'b1);
		while (pending_words.size() < 150)
			add_random_block(1'b0);
		// full store, end on the last stored word
		add_block(BLOCK_DEPTH, PAR_ANY, 1'b0);
		while (pending_words.size() < 230)
			add_random_block(1'b0);
		// overflow, end on a dropped word
		add_block(BLOCK_DEPTH + 3, PAR_ANY, 1'b0);
		add_random_block(1'b1);
		while (pending_words.size() < ITEM_TARGET)
			add_random_block(1'b0);
		for (i = pending_words.size() - TAIL_ITEMS; i < pending_words.size(); i++)
			pending_words[i].gap_after = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while ((pending_words.size() != 0 || in_valid || expected_order.size() != 0) &&
				stuck_cycles < STUCK_LIMIT)
			@(posedge clk);
		if (stuck_cycles < STUCK_LIMIT)
			repeat (DRAIN_CYCLES) @(posedge clk);
		else
			$display("%0t: no transfer for %0d cycles", $time, stuck_cycles);

		if (stuck_cycles < STUCK_LIMIT && error_count == 0 && expected_order.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
